>>> rtl/pcw_pkg.sv
package pcw_pkg;

    localparam int OFFSET_WIDTH_DEF    = 40;
    localparam int SIGNATURE_BYTES_DEF = 8;

    localparam int FILE_LENGTH_WIDTH = 40;
    localparam int CFG_DATA_WIDTH    = 40;
    localparam int CFG_INDEX_WIDTH   = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILE_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STOP_AT_END = 1'd1;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [31:0] HDR_BYTES     = 32'd8;
    localparam logic [31:0] TRAILER_BYTES = 32'd4;
    // Length field, type field and trailer around the chunk data
    localparam int          FRAME_BYTES   = 12;

    typedef struct packed {
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic [31:0] computed_crc;
        logic [31:0] stored_crc;
        logic        crc_match;
        logic        is_text_chunk;
        logic        is_end_chunk;
        logic        status;
    } rec_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/pcw_in_stage.sv
module pcw_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    input  logic       advance,
    output logic       vld,
    output logic [7:0] byte_q,
    output logic       eof_q
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       eof_reg;
    logic       load;

    // Hold the request while the walker cannot take it
    assign in_stall = vld_reg && !advance;
    assign load     = in_valid && !in_stall;
    assign vld_next = load || (vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
            eof_reg  <= end_of_file;
        end
    end

    assign vld    = vld_reg;
    assign byte_q = byte_reg;
    assign eof_q  = eof_reg;

endmodule

>>> rtl/pcw_walker.sv
module pcw_walker
#(
    parameter int OFFSET_WIDTH    = pcw_pkg::OFFSET_WIDTH_DEF,
    parameter int SIGNATURE_BYTES = pcw_pkg::SIGNATURE_BYTES_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   go,
    input  logic [7:0]                             byte_in,
    input  logic                                   eof_in,
    input  logic [pcw_pkg::FILE_LENGTH_WIDTH-1:0]  file_length,
    input  logic                                   stop_at_end_chunk,
    output logic                                   rec_valid,
    output pcw_pkg::rec_t                          rec,
    output logic [OFFSET_WIDTH-1:0]                rec_offset
);

    localparam logic [2:0] PH_SIG   = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_TRAIL = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    localparam logic [2:0]  PH_START = (SIGNATURE_BYTES > 0) ? PH_SIG : PH_HDR;
    localparam logic [31:0] BL_START = (SIGNATURE_BYTES > 0) ? 32'(SIGNATURE_BYTES)
                                                             : pcw_pkg::HDR_BYTES;
    localparam int CW = OFFSET_WIDTH + 1;

    typedef logic [OFFSET_WIDTH-1:0] off_t;

    logic [2:0]  phase_reg,   phase_next;
    off_t        pos_reg,     pos_next;
    logic [31:0] left_reg,    left_next;
    logic [63:0] hdr_reg,     hdr_next;
    logic [31:0] crc_reg,     crc_next;
    logic [31:0] trl_reg,     trl_next;
    off_t        start_reg,   start_next;

    logic [31:0] left_dec;
    logic [63:0] hdr_shift;
    logic [31:0] trl_shift;
    logic [31:0] crc_upd;
    logic [31:0] crc_fin;
    off_t        flen;
    logic [CW-1:0] need;
    logic [CW-1:0] room;
    logic        over;
    logic        emit;

    assign hdr_shift = {hdr_reg[55:0], byte_in};
    assign trl_shift = {trl_reg[23:0], byte_in};
    assign crc_upd   = pcw_pkg::crc32_byte(crc_reg, byte_in);
    assign crc_fin   = ~crc_reg;
    assign left_dec  = left_reg - 32'd1;

    // Overrun check: start + 12 + length beyond the file
    assign flen = off_t'(file_length);
    assign need = CW'(hdr_shift[63:32]) + CW'(pcw_pkg::FRAME_BYTES);
    assign room = CW'(flen - start_reg);
    assign over = (start_reg > flen) || (need > room);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg + off_t'(1);
        left_next  = left_reg;
        hdr_next   = hdr_reg;
        crc_next   = crc_reg;
        trl_next   = trl_reg;
        start_next = start_reg;
        emit       = 1'b0;
        rec        = '0;

        unique case (phase_reg)
            PH_SIG:
            begin
                if (left_reg <= 32'd1)
                begin
                    phase_next = PH_HDR;
                    left_next  = pcw_pkg::HDR_BYTES;
                    hdr_next   = '0;
                    crc_next   = pcw_pkg::CRC_INIT;
                    trl_next   = '0;
                end
                else
                begin
                    left_next = left_dec;
                end
            end
            PH_HDR:
            begin
                if (left_reg == pcw_pkg::HDR_BYTES)
                begin
                    start_next = pos_reg;
                end
                hdr_next = hdr_shift;
                if (left_reg <= pcw_pkg::TRAILER_BYTES)
                begin
                    crc_next = crc_upd;
                end
                left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    rec.chunk_length  = hdr_shift[63:32];
                    rec.chunk_type    = hdr_shift[31:0];
                    rec.is_text_chunk = (hdr_shift[31:0] == pcw_pkg::TYPE_ITXT);
                    rec.is_end_chunk  = (hdr_shift[31:0] == pcw_pkg::TYPE_IEND);
                    rec.status        = 1'b1;
                    if (over)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_STOP;
                    end
                    else if (hdr_shift[63:32] == 32'd0)
                    begin
                        phase_next = PH_TRAIL;
                        left_next  = pcw_pkg::TRAILER_BYTES;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        left_next  = hdr_shift[63:32];
                    end
                end
            end
            PH_DATA:
            begin
                crc_next  = crc_upd;
                left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    phase_next = PH_TRAIL;
                    left_next  = pcw_pkg::TRAILER_BYTES;
                end
            end
            PH_TRAIL:
            begin
                trl_next  = trl_shift;
                left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    emit              = 1'b1;
                    rec.chunk_length  = hdr_reg[63:32];
                    rec.chunk_type    = hdr_reg[31:0];
                    rec.computed_crc  = crc_fin;
                    rec.stored_crc    = trl_shift;
                    rec.crc_match     = (crc_fin == trl_shift);
                    rec.is_text_chunk = (hdr_reg[31:0] == pcw_pkg::TYPE_ITXT);
                    rec.is_end_chunk  = (hdr_reg[31:0] == pcw_pkg::TYPE_IEND);
                    rec.status        = 1'b0;
                    if (rec.is_end_chunk && stop_at_end_chunk)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        left_next  = pcw_pkg::HDR_BYTES;
                        hdr_next   = '0;
                        crc_next   = pcw_pkg::CRC_INIT;
                        trl_next   = '0;
                    end
                end
            end
            default:
            begin
                // stopped: drop the byte
            end
        endcase

        // Restart the walk for the next file
        if (eof_in)
        begin
            phase_next = PH_START;
            left_next  = BL_START;
            pos_next   = '0;
            hdr_next   = '0;
            crc_next   = pcw_pkg::CRC_INIT;
            trl_next   = '0;
            start_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            left_reg  <= BL_START;
            hdr_reg   <= '0;
            crc_reg   <= pcw_pkg::CRC_INIT;
            trl_reg   <= '0;
            start_reg <= '0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            hdr_reg   <= hdr_next;
            crc_reg   <= crc_next;
            trl_reg   <= trl_next;
            start_reg <= start_next;
        end
    end

    assign rec_valid  = go && emit;
    assign rec_offset = start_reg;

endmodule

>>> rtl/pcw_out_reg.sv
module pcw_out_reg
#(
    parameter int OFFSET_WIDTH = pcw_pkg::OFFSET_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  pcw_pkg::rec_t           rec,
    input  logic [OFFSET_WIDTH-1:0] rec_offset,
    input  logic                    out_stall,
    output logic                    out_valid,
    output pcw_pkg::rec_t           rec_q,
    output logic [OFFSET_WIDTH-1:0] offset_q
);

    logic                    valid_reg;
    logic                    valid_next;
    pcw_pkg::rec_t           rec_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;

    // Hold the record until the sink takes it
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg    <= rec;
            offset_reg <= rec_offset;
        end
    end

    assign out_valid = valid_reg;
    assign rec_q     = rec_reg;
    assign offset_q  = offset_reg;

endmodule

>>> rtl/png_chunk_walker_crc_core.sv
// PNG chunk walker with CRC-32 check. Feed the file one byte per request, in file
// order, with end_of_file on the last byte; the block accepts one byte every clock
// while the result register is not held by out_stall, and returns one record per
// chunk, on the cycle after the chunk's last CRC byte leaves the input register.
// The rate is set by the one-byte CRC-32 update and the byte counter, both done
// combinationally between the input register and the result register. The first
// SIGNATURE_BYTES bytes are skipped unchecked. A chunk whose header puts its end
// past file_length yields a record with status 1 and the walker then ignores bytes
// until end_of_file; with stop_at_end_chunk set it does the same after IEND. The
// byte marked end_of_file always restarts the walk; a partial chunk is dropped.
// Write configuration only while no request is in flight.
module png_chunk_walker_crc_core
#(
    parameter int OFFSET_WIDTH    = pcw_pkg::OFFSET_WIDTH_DEF,
    parameter int SIGNATURE_BYTES = pcw_pkg::SIGNATURE_BYTES_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration
    input  logic                                 cfg_we,
    input  logic [pcw_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pcw_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,

    // byte requests
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic                                 end_of_file,

    // chunk records
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [OFFSET_WIDTH-1:0]              chunk_offset,
    output logic [31:0]                          chunk_length,
    output logic [31:0]                          chunk_type,
    output logic [31:0]                          computed_crc,
    output logic [31:0]                          stored_crc,
    output logic                                 crc_match,
    output logic                                 is_text_chunk,
    output logic                                 is_end_chunk,
    output logic                                 status
);

    logic [pcw_pkg::FILE_LENGTH_WIDTH-1:0] file_length_reg;
    logic                                  stop_at_end_reg;

    logic                    stg_vld;
    logic [7:0]              stg_byte;
    logic                    stg_eof;
    logic                    advance;
    logic                    rec_valid;
    pcw_pkg::rec_t           rec;
    pcw_pkg::rec_t           rec_q;
    logic [OFFSET_WIDTH-1:0] rec_offset;

    // Configuration registers; to be written only while the walker is idle (the block itself does not enforce this).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            stop_at_end_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcw_pkg::CFG_FILE_LENGTH:
                begin
                    file_length_reg <= cfg_data[pcw_pkg::FILE_LENGTH_WIDTH-1:0];
                end
                pcw_pkg::CFG_STOP_AT_END:
                begin
                    stop_at_end_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance the staged byte whenever the result register is free or draining.
    // A byte may produce a record, so never advance into a stalled full result.
    assign advance = stg_vld && (!out_valid || !out_stall);

    pcw_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .advance     (advance),
        .vld         (stg_vld),
        .byte_q      (stg_byte),
        .eof_q       (stg_eof)
    );

    // Chunk parser, CRC and overrun check: one byte per cycle while advance is high
    pcw_walker
    #(
        .OFFSET_WIDTH    (OFFSET_WIDTH),
        .SIGNATURE_BYTES (SIGNATURE_BYTES)
    )
    u_walker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .go                (advance),
        .byte_in           (stg_byte),
        .eof_in            (stg_eof),
        .file_length       (file_length_reg),
        .stop_at_end_chunk (stop_at_end_reg),
        .rec_valid         (rec_valid),
        .rec               (rec),
        .rec_offset        (rec_offset)
    );

    pcw_out_reg #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (rec_valid),
        .rec        (rec),
        .rec_offset (rec_offset),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .rec_q      (rec_q),
        .offset_q   (chunk_offset)
    );

    assign chunk_length  = rec_q.chunk_length;
    assign chunk_type    = rec_q.chunk_type;
    assign computed_crc  = rec_q.computed_crc;
    assign stored_crc    = rec_q.stored_crc;
    assign crc_match     = rec_q.crc_match;
    assign is_text_chunk = rec_q.is_text_chunk;
    assign is_end_chunk  = rec_q.is_end_chunk;
    assign status        = rec_q.status;

endmodule

>>> rtl/pcw_checker.sv
module pcw_checker
#(
    parameter int OFFSET_WIDTH = pcw_pkg::OFFSET_WIDTH_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [OFFSET_WIDTH-1:0] chunk_offset,
    input logic [31:0]             chunk_length,
    input logic [31:0]             chunk_type,
    input logic [31:0]             computed_crc,
    input logic [31:0]             stored_crc,
    input logic                    crc_match,
    input logic                    is_text_chunk,
    input logic                    is_end_chunk,
    input logic                    status
);

    // A stalled record stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chunk_offset) && $stable(chunk_length)
            && $stable(chunk_type) && $stable(computed_crc) && $stable(stored_crc))
        else $error("stalled record changed");

    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> crc_match == (computed_crc == stored_crc))
        else $error("crc_match disagrees with the CRC fields");

    a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> computed_crc == 32'd0 && stored_crc == 32'd0 && !crc_match)
        else $error("overrun record carries CRC data");

    a_type_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_text_chunk == (chunk_type == pcw_pkg::TYPE_ITXT)
            && is_end_chunk == (chunk_type == pcw_pkg::TYPE_IEND))
        else $error("type flags disagree with chunk_type");

endmodule

bind png_chunk_walker_crc_core pcw_checker #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_pcw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chunk_offset  (chunk_offset),
    .chunk_length  (chunk_length),
    .chunk_type    (chunk_type),
    .computed_crc  (computed_crc),
    .stored_crc    (stored_crc),
    .crc_match     (crc_match),
    .is_text_chunk (is_text_chunk),
    .is_end_chunk  (is_end_chunk),
    .status        (status)
);

>>> tb/chunk_check_pkg.sv
package chunk_check_pkg;
    import pcw_pkg::*;

    typedef enum logic [2:0] {
        WALK_SIGNATURE,
        WALK_HEADER,
        WALK_DATA,
        WALK_TRAILER,
        WALK_HALTED
    } walk_phase_e;

    typedef struct packed {
        logic [OFFSET_WIDTH_DEF-1:0] offset;
        rec_t                        rec;
    } chunk_record_t;

    // Reflected CRC-32, fed one bit at a time, LSB first
    function automatic logic [31:0] crc32_update(input logic [31:0] state,
                                                 input logic [7:0]  value);
        logic [31:0] r;
        logic        fb;
        int          i;
        r = state;
        for (i = 0; i < 8; i++)
        begin
            fb = r[0] ^ value[i];
            r  = (r >> 1) ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    class chunk_scoreboard;
        logic [FILE_LENGTH_WIDTH-1:0] file_length;
        logic                         stop_at_end;

        walk_phase_e                  phase;
        logic [OFFSET_WIDTH_DEF-1:0]  position;
        logic [31:0]                  remaining;
        logic [63:0]                  header;
        logic [31:0]                  crc;
        logic [31:0]                  trailer;
        logic [OFFSET_WIDTH_DEF-1:0]  chunk_start;

        chunk_record_t                expected_records[$];
        int unsigned                  errors;

        function new();
            file_length = '0;
            stop_at_end = 1'b1;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            if (SIGNATURE_BYTES_DEF > 0)
            begin
                phase     = WALK_SIGNATURE;
                remaining = SIGNATURE_BYTES_DEF;
            end
            else
            begin
                phase     = WALK_HEADER;
                remaining = HDR_BYTES;
            end
            position    = '0;
            header      = '0;
            crc         = CRC_INIT;
            trailer     = '0;
            chunk_start = '0;
        endfunction

        function void open_chunk();
            phase     = WALK_HEADER;
            remaining = HDR_BYTES;
            header    = '0;
            crc       = CRC_INIT;
            trailer   = '0;
        endfunction

        function void set_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                   input logic [CFG_DATA_WIDTH-1:0]  value);
            if (idx == CFG_FILE_LENGTH)
                file_length = value[FILE_LENGTH_WIDTH-1:0];
            else if (idx == CFG_STOP_AT_END)
                stop_at_end = value[0];
        endfunction

        // Add a prediction at the tail of the queue
        function void queue_record(input chunk_record_t r);
            expected_records.insert(expected_records.size(), r);
        endfunction

        function chunk_record_t make_record(input logic [31:0] crc_calc,
                                            input logic [31:0] crc_read,
                                            input logic        match,
                                            input logic        overrun);
            chunk_record_t r;
            r.offset            = chunk_start;
            r.rec.chunk_length  = header[63:32];
            r.rec.chunk_type    = header[31:0];
            r.rec.computed_crc  = crc_calc;
            r.rec.stored_crc    = crc_read;
            r.rec.crc_match     = match;
            r.rec.is_text_chunk = (header[31:0] == TYPE_ITXT);
            r.rec.is_end_chunk  = (header[31:0] == TYPE_IEND);
            r.rec.status        = overrun;
            return r;
        endfunction

        // Advance the walk by one accepted byte; queue the chunk record it closes
        function void note_byte(input logic [7:0] b, input logic eof);
            logic [OFFSET_WIDTH_DEF-1:0] here;
            logic [63:0]                 len64;
            logic [63:0]                 flen;
            logic [63:0]                 st;
            logic [31:0]                 final_crc;
            here     = position;
            position = position + 1'b1;
            case (phase)
                WALK_SIGNATURE:
                begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        open_chunk();
                end
                WALK_HEADER:
                begin
                    if (remaining == HDR_BYTES)
                        chunk_start = here;
                    header = {header[55:0], b};
                    if (remaining <= TRAILER_BYTES)
                        crc = crc32_update(crc, b);
                    remaining--;
                    if (remaining == 0)
                    begin
                        len64 = {32'd0, header[63:32]};
                        flen  = 64'(file_length);
                        st    = 64'(chunk_start);
                        if (st > flen || len64 + FRAME_BYTES > flen - st)
                        begin
                            queue_record(make_record('0, '0, 1'b0, 1'b1));
                            phase = WALK_HALTED;
                        end
                        else if (header[63:32] == 0)
                        begin
                            phase     = WALK_TRAILER;
                            remaining = TRAILER_BYTES;
                        end
                        else
                        begin
                            phase     = WALK_DATA;
                            remaining = header[63:32];
                        end
                    end
                end
                WALK_DATA:
                begin
                    crc = crc32_update(crc, b);
                    remaining--;
                    if (remaining == 0)
                    begin
                        phase     = WALK_TRAILER;
                        remaining = TRAILER_BYTES;
                    end
                end
                WALK_TRAILER:
                begin
                    trailer = {trailer[23:0], b};
                    remaining--;
                    if (remaining == 0)
                    begin
                        final_crc = ~crc;
                        queue_record(
                            make_record(final_crc, trailer, final_crc == trailer, 1'b0));
                        if (header[31:0] == TYPE_IEND && stop_at_end)
                            phase = WALK_HALTED;
                        else
                            open_chunk();
                    end
                end
                default:
                begin
                end
            endcase
            if (eof)
                restart();
        endfunction

        function void check_field(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_record(input chunk_record_t got);
            chunk_record_t want;
            if (expected_records.size() == 0)
            begin
                $display("%0t: unexpected chunk record, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            check_field("chunk_offset",  64'(want.offset),            64'(got.offset));
            check_field("chunk_length",  64'(want.rec.chunk_length),  64'(got.rec.chunk_length));
            check_field("chunk_type",    64'(want.rec.chunk_type),    64'(got.rec.chunk_type));
            check_field("computed_crc",  64'(want.rec.computed_crc),  64'(got.rec.computed_crc));
            check_field("stored_crc",    64'(want.rec.stored_crc),    64'(got.rec.stored_crc));
            check_field("crc_match",     64'(want.rec.crc_match),     64'(got.rec.crc_match));
            check_field("is_text_chunk", 64'(want.rec.is_text_chunk),
                        64'(got.rec.is_text_chunk));
            check_field("is_end_chunk",  64'(want.rec.is_end_chunk),
                        64'(got.rec.is_end_chunk));
            check_field("status",        64'(want.rec.status),        64'(got.rec.status));
        endfunction

        function int pending();
            return expected_records.size();
        endfunction
    endclass

endpackage

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcw_pkg::*;
    import chunk_check_pkg::*;

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                cfg_we        = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]          cfg_index     = CFG_FILE_LENGTH;
    logic [CFG_DATA_WIDTH-1:0]           cfg_data      = '0;
    logic                                in_valid      = 1'b0;
    logic                                in_stall;
    logic [7:0]                          data_byte     = 8'd0;
    logic                                end_of_file   = 1'b0;
    logic                                out_valid;
    logic                                out_stall     = 1'b0;
    logic [OFFSET_WIDTH_DEF-1:0]         chunk_offset;
    logic [31:0]                         chunk_length;
    logic [31:0]                         chunk_type;
    logic [31:0]                         computed_crc;
    logic [31:0]                         stored_crc;
    logic                                crc_match;
    logic                                is_text_chunk;
    logic                                is_end_chunk;
    logic                                status;

    chunk_scoreboard                     sb;
    int                                  send_idle_pct = 0;
    int                                  recv_idle_pct = 0;
    int unsigned                         bytes_sent    = 0;
    // bytes of the file being built, sent in order, end_of_file on the last
    logic [7:0]                          file_bytes[$];

    png_chunk_walker_crc_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chunk_offset  (chunk_offset),
        .chunk_length  (chunk_length),
        .chunk_type    (chunk_type),
        .computed_crc  (computed_crc),
        .stored_crc    (stored_crc),
        .crc_match     (crc_match),
        .is_text_chunk (is_text_chunk),
        .is_end_chunk  (is_end_chunk),
        .status        (status)
    );

    // 20 ns clock
    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Record side: stall at random; drive on the falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check every record taken at a rising edge against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_record({chunk_offset, chunk_length, chunk_type, computed_crc,
                             stored_crc, crc_match, is_text_chunk, is_end_chunk, status});
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Append one byte to the file being built
    function void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    // Append a 32-bit word, most significant byte first
    function void push_word(input logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    // Append a complete chunk; spoil flips one bit of the trailer CRC
    function void add_chunk(input logic [31:0] len, input logic [31:0] kind, input bit spoil);
        logic [31:0] crc;
        logic [7:0]  b;
        int          k;
        crc = CRC_INIT;
        push_word(len);
        push_word(kind);
        for (k = 3; k >= 0; k--)
            crc = crc32_update(crc, kind[8*k +: 8]);
        repeat (len)
        begin
            b = 8'($urandom);
            add_byte(b);
            crc = crc32_update(crc, b);
        end
        crc = ~crc;
        if (spoil)
            crc = crc ^ (32'd1 << $urandom_range(31));
        push_word(crc);
    endfunction

    // Send the built file one request per byte, end_of_file on the last byte.
    // Hold each request until the block takes it, then tell the predictor.
    task automatic stream_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid    <= 1'b1;
            data_byte   <= file_bytes[k];
            end_of_file <= (k == file_bytes.size() - 1);
            do
                @(posedge clk);
            while (in_stall);
            sb.note_byte(file_bytes[k], k == file_bytes.size() - 1);
            bytes_sent++;
            @(negedge clk);
        end
        file_bytes.delete();
    endtask

    // Drop the request line and hold until every predicted record is out
    task automatic wait_for_records();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0]  value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int                        ph;
        int unsigned               goal;
        int                        pick;
        int                        roll;
        int                        chunks;
        int                        c;
        int                        keep;
        logic [31:0]               kind;
        logic [CFG_DATA_WIDTH-1:0] flen;
        logic                      stop_bit;

        sb = new();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings give file_length zero, so the first header
        // overruns; carry end_of_file on that same header byte. Length all ones,
        // type iTXt, signature bytes at both extremes.
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (6)
            add_byte(8'($urandom));
        push_word(32'hFFFF_FFFF);
        push_word(TYPE_ITXT);
        stream_file();
        // end of file in the middle of the signature
        add_byte(8'h5A);
        stream_file();

        // Random files over four settings. Sender and receiver idle rates swap
        // between the first two, then neither side idles.
        for (ph = 0; ph < 4; ph++)
        begin
            wait_for_records();
            // let the last byte clear the pipeline before touching registers
            repeat (4)
                @(negedge clk);
            case (ph)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 47;
                    flen          = 40'hFF_FFFF_FFFF;
                    stop_bit      = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 31;
                    flen          = CFG_DATA_WIDTH'($urandom_range(40, 120));
                    stop_bit      = 1'b0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    flen          = CFG_DATA_WIDTH'($urandom_range(150, 400));
                    stop_bit      = 1'b1;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    flen          = '0;
                    stop_bit      = 1'b0;
                end
            endcase
            write_reg(CFG_FILE_LENGTH, flen);
            write_reg(CFG_STOP_AT_END, {{(CFG_DATA_WIDTH-1){1'b0}}, stop_bit});

            goal = bytes_sent + ((ph == 3) ? 120 : 460);
            while (bytes_sent < goal)
            begin
                // now and then hold off until the block has drained
                if ($urandom_range(19) == 0)
                    wait_for_records();

                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    // noise: random bytes of random length
                    repeat ($urandom_range(1, 40))
                        add_byte(8'($urandom));
                end
                else
                begin
                    repeat (8)
                        add_byte(8'($urandom));
                    chunks = $urandom_range(1, 5);
                    for (c = 0; c < chunks; c++)
                    begin
                        roll = $urandom_range(99);
                        if (roll < 15)
                            kind = TYPE_ITXT;
                        else if (roll < 30)
                            kind = TYPE_IEND;
                        else
                            kind = $urandom;
                        roll = $urandom_range(99);
                        if (roll < 8)
                        begin
                            // huge random length: overrun, or cut short by end of file
                            push_word($urandom);
                            push_word(kind);
                            repeat ($urandom_range(0, 6))
                                add_byte(8'($urandom));
                            break;
                        end
                        add_chunk((roll < 75) ? $urandom_range(0, 16) : $urandom_range(17, 48),
                                  kind, $urandom_range(99) < 20);
                    end
                    // truncate some files mid-chunk
                    if ($urandom_range(99) < 15)
                    begin
                        keep = $urandom_range(1, file_bytes.size());
                        while (file_bytes.size() > keep)
                            void'(file_bytes.pop_back());
                    end
                    else if ($urandom_range(3) == 0)
                    begin
                        repeat ($urandom_range(1, 3))
                            add_byte(8'($urandom));
                    end
                end
                stream_file();
            end
        end

        wait_for_records();
        repeat (8)
            @(negedge clk);
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
